/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on i_clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BFSO_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BFSO_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/bfso_pkg.sv */
// ----------------------------------------------------------------------------
// bfso_pkg
// field widths, action codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package bfso_pkg;

    localparam int ACT_W   = 2;
    localparam int FREQ_W  = 24;
    localparam int SLIDE_W = 20;
    localparam int CFG_W   = 48;
    localparam int MUL_W   = 32;
    localparam int FRAC_W  = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = 48'd24019198012643;

    // action codes
    localparam logic [ACT_W-1:0] ACT_TICK        = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SET_FREQ    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RESET_PHASE = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_TMUL_LO,
        OP_TMUL_HI,
        OP_TSUM,
        OP_STEP_SET,
        OP_GDIV_START,
        OP_GSTORE,
        OP_CLR_PHASE,
        OP_GLIDE,
        OP_ADVANCE,
        OP_RES_DIRECT,
        OP_FDIV_START,
        OP_FMUL,
        OP_FRES
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             slide_zero;
        logic             muted;
        logic             wrap;
        logic             div_busy;
    } t_dp_status;

endpackage

/* hdl/bfso_div.sv */
// ----------------------------------------------------------------------------
// bfso_div
// restoring divider, one quotient bit per cycle, preloadable remainder
// ----------------------------------------------------------------------------
module bfso_div #(
    parameter int QW = 40,
    parameter int DW = 33
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [QW-1:0]              i_num,
    input  logic [DW-1:0]              i_rem,
    input  logic [DW-1:0]              i_den,
    input  logic [$clog2(QW+1)-1:0]    i_iters,
    output logic                       o_busy,
    output logic [QW-1:0]              o_quot
);

    localparam int CNT_W = $clog2(QW+1);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_den;
    logic [QW-1:0]     r_quot;

    logic [DW:0]       w_trial;
    logic [DW:0]       w_sub;
    logic              w_fit;

    assign w_trial = {r_rem, r_quot[QW-1]};
    assign w_sub   = w_trial - {1'b0, r_den};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_iters;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_rem;
            r_den  <= i_den;
            r_quot <= i_num;
        end else if (r_busy) begin
            r_rem  <= w_fit ? w_sub[DW-1:0] : w_trial[DW-1:0];
            r_quot <= {r_quot[QW-2:0], w_fit};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

/* hdl/bfso_dp.sv */
// ----------------------------------------------------------------------------
// bfso_dp
// oscillator datapath: phase, increment, glide, shared multiplier and divider
// ----------------------------------------------------------------------------
module bfso_dp #(
    parameter int PHASE_BITS       = 32,
    parameter int GLIDE_COUNT_BITS = 20,
    parameter int OUT_BITS         = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bfso_pkg::t_dp_cmd                 i_cmd,
    input  logic [bfso_pkg::ACT_W-1:0]        i_action,
    input  logic [bfso_pkg::FREQ_W-1:0]       i_frequency,
    input  logic [bfso_pkg::SLIDE_W-1:0]      i_slide_samples,
    input  logic                              i_cfg_we,
    input  logic [bfso_pkg::CFG_W-1:0]        i_cfg_data,
    output bfso_pkg::t_dp_status              o_status,
    output logic signed [OUT_BITS-1:0]        o_sample,
    output logic                              o_muted
);

    localparam int P     = PHASE_BITS;
    localparam int GCB   = GLIDE_COUNT_BITS;
    localparam int SLW   = bfso_pkg::SLIDE_W;
    localparam int FW    = bfso_pkg::FREQ_W;
    localparam int MW    = bfso_pkg::MUL_W;
    localparam int SW    = P + 8;
    localparam int GSW   = P + 9;
    localparam int CW    = (GCB < SLW) ? GCB : SLW;
    localparam int DW    = (P + 1 > CW) ? P + 1 : CW;
    localparam int QW    = (P + 8 > bfso_pkg::FRAC_W) ? P + 8 : bfso_pkg::FRAC_W;
    localparam int CNT_W = $clog2(QW+1);
    localparam int LW    = P + OUT_BITS;
    localparam int F1W   = P + bfso_pkg::FRAC_W;
    localparam int LIN_UP = (OUT_BITS - 1 >= P) ? OUT_BITS - 1 - P : 0;
    localparam int LIN_DN = (OUT_BITS - 1 >= P) ? 0 : P - OUT_BITS + 1;
    localparam int F1_UP  = (P <= bfso_pkg::FRAC_W) ? bfso_pkg::FRAC_W - P : 0;
    localparam int F1_DN  = (P <= bfso_pkg::FRAC_W) ? 0 : P - bfso_pkg::FRAC_W;

    localparam logic [SW-1:0]       N_STEP  = {7'b0, 1'b1, {P{1'b0}}};
    localparam logic [P+8:0]        N_SUM   = {8'b0, 1'b1, {P{1'b0}}};
    localparam logic [P+9:0]        N_WIDE  = {9'b0, 1'b1, {P{1'b0}}};
    localparam logic [P+9:0]        N2_WIDE = {8'b0, 1'b1, {(P+1){1'b0}}};
    localparam logic [CW-1:0]       SLIDE_MAX = '1;
    localparam logic [OUT_BITS-1:0] OUT_HI  = {1'b0, {(OUT_BITS-1){1'b1}}};

    // model state and config
    logic [bfso_pkg::CFG_W-1:0] r_inc;
    logic [P-1:0]               r_phase;
    logic [SW-1:0]              r_step;
    logic [GSW-1:0]             r_gstep;
    logic [GCB-1:0]             r_gleft;

    // working registers
    logic [bfso_pkg::ACT_W-1:0] r_action;
    logic [FW-1:0]              r_freq;
    logic [SLW-1:0]             r_slide;
    logic [2*MW-1:0]            r_prod;
    logic [2*FW-1:0]            r_acc;
    logic [SW-1:0]              r_target;
    logic [bfso_pkg::FRAC_W-1:0] r_f1;
    logic                       r_neg;
    logic [OUT_BITS-1:0]        r_res_sample;
    logic                       r_res_muted;
    logic [OUT_BITS-1:0]        r_out_sample;
    logic                       r_out_muted;

    logic [P+8:0]               w_sum;
    logic                       w_muted;
    logic                       w_wrap;
    logic [P+9:0]               w_lin;
    logic [P+9:0]               w_lin_abs;
    logic [LW-1:0]              w_lin_wide;
    logic [OUT_BITS-1:0]        w_lin_mag;
    logic [SW-1:0]              w_u;
    logic [F1W-1:0]             w_f1_wide;
    logic [P+9:0]               w_v;
    logic [P+9:0]               w_v_abs;
    logic [P+8:0]               w_diff;
    logic [P+8:0]               w_diff_abs;
    logic [CW-1:0]              w_slide_c;
    logic [P+9:0]               w_ns;
    logic [SW-1:0]              w_ns_c;
    logic [3*FW-1:0]            w_full;
    logic [MW-1:0]              w_mul_a;
    logic [MW-1:0]              w_mul_b;
    logic                       w_mul_en;
    logic [2*MW-1:0]            w_mul;
    logic                       w_div_start;
    logic [QW-1:0]              w_div_num;
    logic [DW-1:0]              w_div_rem;
    logic [DW-1:0]              w_div_den;
    logic [CNT_W-1:0]           w_div_iters;
    logic                       w_div_busy;
    logic [QW-1:0]              w_quot;
    logic [SW-1:0]              w_gq;

    function automatic logic [OUT_BITS-1:0] f_apply_sign(
        input logic [OUT_BITS-1:0] mag,
        input logic                neg
    );
        logic [OUT_BITS-1:0] res;
        if (neg) begin
            res = ~mag + OUT_BITS'(1);
        end else if (mag[OUT_BITS-1]) begin
            res = OUT_HI;
        end else begin
            res = mag;
        end
        return res;
    endfunction

    // span classification
    assign w_sum   = (P+9)'(r_phase) + {1'b0, r_step};
    assign w_muted = (r_step > N_STEP);
    assign w_wrap  = (w_sum > N_SUM);

    // linear span: 2p + d - n
    assign w_lin      = {9'b0, r_phase, 1'b0} + {2'b0, r_step} - N_WIDE;
    assign w_lin_abs  = w_lin[P+9] ? (~w_lin + (P+10)'(1)) : w_lin;
    assign w_lin_wide = (LW'(w_lin_abs[P:0]) << LIN_UP) >> LIN_DN;
    assign w_lin_mag  = w_lin_wide[OUT_BITS-1:0];

    // wrapped span: (n - d) and (2n - 2p - d)
    assign w_u       = N_STEP - r_step;
    assign w_f1_wide = (F1W'(w_u[P-1:0]) << F1_UP) >> F1_DN;
    assign w_v       = N2_WIDE - {9'b0, r_phase, 1'b0} - {2'b0, r_step};
    assign w_v_abs   = w_v[P+9] ? (~w_v + (P+10)'(1)) : w_v;

    // glide setup
    assign w_diff     = {1'b0, r_target} - {1'b0, r_step};
    assign w_diff_abs = w_diff[P+8] ? (~w_diff + (P+9)'(1)) : w_diff;
    assign w_slide_c  = (r_slide > SLW'(SLIDE_MAX)) ? SLIDE_MAX : r_slide[CW-1:0];
    assign w_gq       = w_quot[SW-1:0];

    // glide step, clamped to the increment range
    assign w_ns = {2'b0, r_step} + {r_gstep[GSW-1], r_gstep};
    always_comb begin
        if (w_ns[P+9]) begin
            w_ns_c = '0;
        end else if (w_ns[P+8]) begin
            w_ns_c = '1;
        end else begin
            w_ns_c = w_ns[SW-1:0];
        end
    end

    // target increment from the two partial products
    assign w_full = {r_prod[2*FW-1:0], {FW{1'b0}}} + {{FW{1'b0}}, r_acc};

    // shared multiplier operands
    always_comb begin
        w_mul_a  = '0;
        w_mul_b  = '0;
        w_mul_en = 1'b0;
        case (i_cmd.op)
            bfso_pkg::OP_TMUL_LO: begin
                w_mul_a  = MW'(r_freq);
                w_mul_b  = MW'(r_inc[FW-1:0]);
                w_mul_en = 1'b1;
            end
            bfso_pkg::OP_TMUL_HI: begin
                w_mul_a  = MW'(r_freq);
                w_mul_b  = MW'(r_inc[2*FW-1:FW]);
                w_mul_en = 1'b1;
            end
            bfso_pkg::OP_FMUL: begin
                w_mul_a  = r_f1;
                w_mul_b  = w_quot[MW-1:0];
                w_mul_en = 1'b1;
            end
            default: begin
            end
        endcase
    end
    assign w_mul = w_mul_a * w_mul_b;

    // divider setup
    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_rem   = '0;
        w_div_den   = '0;
        w_div_iters = '0;
        case (i_cmd.op)
            bfso_pkg::OP_GDIV_START: begin
                w_div_start = 1'b1;
                w_div_num   = QW'(w_diff_abs[SW-1:0]);
                w_div_den   = DW'(w_slide_c);
                w_div_iters = CNT_W'(QW);
            end
            bfso_pkg::OP_FDIV_START: begin
                w_div_start = 1'b1;
                w_div_rem   = DW'(w_v_abs[P:0]);
                w_div_den   = DW'(r_step[P:0]);
                w_div_iters = CNT_W'(bfso_pkg::FRAC_W);
            end
            default: begin
            end
        endcase
    end

    bfso_div #(
        .QW (QW),
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_rem   (w_div_rem),
        .i_den   (w_div_den),
        .i_iters (w_div_iters),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // oscillator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc   <= bfso_pkg::CFG_RESET;
            r_phase <= '0;
            r_step  <= '0;
            r_gstep <= '0;
            r_gleft <= '0;
        end else begin
            if (i_cfg_we) begin
                r_inc <= i_cfg_data;
            end
            case (i_cmd.op)
                bfso_pkg::OP_CLR_PHASE: begin
                    r_phase <= '0;
                end
                bfso_pkg::OP_STEP_SET: begin
                    r_step  <= r_target;
                    r_gleft <= '0;
                end
                bfso_pkg::OP_GSTORE: begin
                    r_gstep <= r_neg ? (~{1'b0, w_gq} + GSW'(1)) : {1'b0, w_gq};
                    r_gleft <= GCB'(w_slide_c);
                end
                bfso_pkg::OP_GLIDE: begin
                    if (r_gleft != '0) begin
                        r_step  <= w_ns_c;
                        r_gleft <= r_gleft - GCB'(1);
                    end
                end
                bfso_pkg::OP_ADVANCE: begin
                    r_phase <= r_phase + r_step[P-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= w_mul;
        end
        if (i_cmd.out_load) begin
            r_out_sample <= r_res_sample;
            r_out_muted  <= r_res_muted;
        end
        case (i_cmd.op)
            bfso_pkg::OP_LOAD: begin
                r_action <= i_action;
                r_freq   <= i_frequency;
                r_slide  <= i_slide_samples;
            end
            bfso_pkg::OP_TMUL_HI: begin
                r_acc <= r_prod[2*FW-1:0];
            end
            bfso_pkg::OP_TSUM: begin
                // 72-bit product shifted down always fits the increment range
                r_target <= w_full[3*FW-1 -: SW];
            end
            bfso_pkg::OP_GDIV_START: begin
                r_neg <= w_diff[P+8];
            end
            bfso_pkg::OP_FDIV_START: begin
                r_neg <= w_v[P+9];
                r_f1  <= w_f1_wide[bfso_pkg::FRAC_W-1:0];
            end
            bfso_pkg::OP_RES_DIRECT: begin
                if (w_muted) begin
                    r_res_sample <= '0;
                    r_res_muted  <= 1'b1;
                end else begin
                    r_res_sample <= f_apply_sign(w_lin_mag, w_lin[P+9]);
                    r_res_muted  <= 1'b0;
                end
            end
            bfso_pkg::OP_FRES: begin
                r_res_sample <= f_apply_sign({1'b0, r_prod[2*MW-1 -: (OUT_BITS-1)]}, r_neg);
                r_res_muted  <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign o_status.action     = r_action;
    assign o_status.slide_zero = (r_slide == '0);
    assign o_status.muted      = w_muted;
    assign o_status.wrap       = w_wrap;
    assign o_status.div_busy   = w_div_busy;

    assign o_sample = r_out_sample;
    assign o_muted  = r_out_muted;

endmodule

/* hdl/bfso_ctrl.sv */
// ----------------------------------------------------------------------------
// bfso_ctrl
// sequencer for set-frequency, phase reset and sample-tick requests
// ----------------------------------------------------------------------------
module bfso_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  bfso_pkg::t_dp_status i_status,
    output bfso_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [14:0] {
        S_IDLE     = 15'h0001,
        S_DECODE   = 15'h0002,
        S_TMUL_LO  = 15'h0004,
        S_TMUL_HI  = 15'h0008,
        S_TSUM     = 15'h0010,
        S_TAPPLY   = 15'h0020,
        S_GDIV     = 15'h0040,
        S_GSTORE   = 15'h0080,
        S_GLIDE    = 15'h0100,
        S_ADVANCE  = 15'h0200,
        S_CLASSIFY = 15'h0400,
        S_FDIV     = 15'h0800,
        S_FMUL     = 15'h1000,
        S_FRES     = 15'h2000,
        S_DONE     = 15'h4000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = bfso_pkg::OP_NONE;
        o_cmd.out_load = 1'b0;
        o_in_ready     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = bfso_pkg::OP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.action == bfso_pkg::ACT_TICK) begin
                    n_state = S_GLIDE;
                end else if (i_status.action == bfso_pkg::ACT_SET_FREQ) begin
                    n_state = S_TMUL_LO;
                end else if (i_status.action == bfso_pkg::ACT_RESET_PHASE) begin
                    o_cmd.op = bfso_pkg::OP_CLR_PHASE;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_TMUL_LO: begin
                o_cmd.op = bfso_pkg::OP_TMUL_LO;
                n_state  = S_TMUL_HI;
            end
            S_TMUL_HI: begin
                o_cmd.op = bfso_pkg::OP_TMUL_HI;
                n_state  = S_TSUM;
            end
            S_TSUM: begin
                o_cmd.op = bfso_pkg::OP_TSUM;
                n_state  = S_TAPPLY;
            end
            S_TAPPLY: begin
                if (i_status.slide_zero) begin
                    o_cmd.op = bfso_pkg::OP_STEP_SET;
                    n_state  = S_IDLE;
                end else begin
                    o_cmd.op = bfso_pkg::OP_GDIV_START;
                    n_state  = S_GDIV;
                end
            end
            S_GDIV: begin
                if (!i_status.div_busy) begin
                    n_state = S_GSTORE;
                end
            end
            S_GSTORE: begin
                o_cmd.op = bfso_pkg::OP_GSTORE;
                n_state  = S_IDLE;
            end
            S_GLIDE: begin
                o_cmd.op = bfso_pkg::OP_GLIDE;
                n_state  = S_ADVANCE;
            end
            S_ADVANCE: begin
                o_cmd.op = bfso_pkg::OP_ADVANCE;
                n_state  = S_CLASSIFY;
            end
            S_CLASSIFY: begin
                if (i_status.muted || !i_status.wrap) begin
                    o_cmd.op = bfso_pkg::OP_RES_DIRECT;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = bfso_pkg::OP_FDIV_START;
                    n_state  = S_FDIV;
                end
            end
            S_FDIV: begin
                if (!i_status.div_busy) begin
                    n_state = S_FMUL;
                end
            end
            S_FMUL: begin
                o_cmd.op = bfso_pkg::OP_FMUL;
                n_state  = S_FRES;
            end
            S_FRES: begin
                o_cmd.op = bfso_pkg::OP_FRES;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* hdl/box_filtered_saw_oscillator.sv */
// ----------------------------------------------------------------------------
// box_filtered_saw_oscillator
// anti-aliased sawtooth oscillator with linear glide, one sample per tick
// ----------------------------------------------------------------------------
// the block takes one request at a time. a sample tick returns one sample;
// when the swept span stays inside one cycle or the oscillator is muted the
// result is formed directly, and when the span wraps it waits on the 32-step
// fraction division in the shared radix-2 divider. a set-frequency request
// with glide waits on the glide-step division in the same divider; without
// glide it needs no division. the result sits in an output register, so the
// next request is taken while a sample waits.
// the config register (inc_per_freq_unit) is always ready and must only be
// written while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module box_filtered_saw_oscillator #(
    parameter int PHASE_BITS       = 32,
    parameter int GLIDE_COUNT_BITS = 20,
    parameter int OUT_BITS         = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [bfso_pkg::ACT_W-1:0]    i_action,
    input  logic [bfso_pkg::FREQ_W-1:0]   i_frequency,
    input  logic [bfso_pkg::SLIDE_W-1:0]  i_slide_samples,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [OUT_BITS-1:0]    o_sample,
    output logic                          o_muted,
    // config write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bfso_pkg::CFG_W-1:0]    i_cfg_data
);

    bfso_pkg::t_dp_cmd    w_cmd;
    bfso_pkg::t_dp_status w_status;

    // config writes are always accepted and registered directly
    assign o_cfg_ready = 1'b1;

    // sequencer: decodes the request and steps the datapath
    bfso_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // datapath: phase accumulator, glide, target multiply, span averaging
    bfso_dp #(
        .PHASE_BITS       (PHASE_BITS),
        .GLIDE_COUNT_BITS (GLIDE_COUNT_BITS),
        .OUT_BITS         (OUT_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_action        (i_action),
        .i_frequency     (i_frequency),
        .i_slide_samples (i_slide_samples),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .o_status        (w_status),
        .o_sample        (o_sample),
        .o_muted         (o_muted)
    );

    // divider is never left running once the sequencer is back in idle
    `BFSO_ASSERT_IMP(a_idle_div_free, o_in_ready, !w_status.div_busy, "divider busy in idle")

    // a taken request closes the request channel in the following cycle
    `BFSO_ASSERT_NXT(a_accept_busy, i_in_valid && o_in_ready, !o_in_ready, "ready after accept")

    // a pending sample is never overwritten before it is taken
    `BFSO_ASSERT_IMP(a_no_overwrite, w_cmd.out_load, !o_out_valid || i_out_ready, "result overwrite")

    // a muted result carries a zero sample
    `BFSO_ASSERT_IMP(a_muted_zero, o_out_valid && o_muted, o_sample == '0, "muted sample not zero")

endmodule

/* tb/box_filtered_saw_oscillator_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_filtered_saw_oscillator_test
// self-checking bench: a request queue feeds a clocked driver, a clocked
// monitor predicts each tick's box-filtered saw sample from its own oscillator
// state and compares it with the block's output, over several increment scales
// ----------------------------------------------------------------------------
module box_filtered_saw_oscillator_test;

    localparam int ACT_W   = bfso_pkg::ACT_W;
    localparam int FREQ_W  = bfso_pkg::FREQ_W;
    localparam int SLIDE_W = bfso_pkg::SLIDE_W;
    localparam int CFG_W   = bfso_pkg::CFG_W;

    localparam int PHASE_W       = 32;
    localparam int OUT_W         = 24;
    localparam int STEP_W        = PHASE_W + 8;
    localparam int FRACTION_W    = 32;
    localparam int SETTLE_CYCLES = 64;     // longest silent request is a glide setup
    localparam int MAX_REPORTS   = 200;
    localparam int RESET_CYCLES  = 7;

    localparam longint unsigned CYCLE    = 64'h1_0000_0000;
    localparam longint unsigned STEP_MAX = (64'd1 << STEP_W) - 64'd1;
    localparam longint          OUT_HI   = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
    localparam longint          OUT_LO   = -OUT_HI - 64'sd1;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [FREQ_W-1:0]  frequency;
        logic [SLIDE_W-1:0] slide;
    } t_osc_req;

    typedef struct packed {
        logic signed [OUT_W-1:0] sample;
        logic                    muted;
    } t_osc_sample;

    // clock, reset and block ports; the driven ones are known from time zero
    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    i_in_valid      = 1'b0;
    logic                    o_in_ready;
    logic [ACT_W-1:0]        i_action        = '0;
    logic [FREQ_W-1:0]       i_frequency     = '0;
    logic [SLIDE_W-1:0]      i_slide_samples = '0;
    logic                    o_out_valid;
    logic                    i_out_ready     = 1'b0;
    logic signed [OUT_W-1:0] o_sample;
    logic                    o_muted;
    logic                    i_cfg_valid     = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_W-1:0]        i_cfg_data      = '0;

    // pending requests and the samples we expect back, oldest first
    t_osc_req    req_q[$];
    t_osc_sample sample_q[$];

    // predicted oscillator state and its copy of the increment scale
    logic [CFG_W-1:0]   inc_cfg    = bfso_pkg::CFG_RESET;
    logic [PHASE_W-1:0] osc_phase  = '0;
    logic [STEP_W-1:0]  osc_step   = '0;
    longint             glide_inc  = 0;
    logic [SLIDE_W-1:0] glide_left = '0;

    // idling control: calm turns off both sides' random gaps
    logic calm       = 1'b0;
    int   send_gap   = 0;
    int   stall_left = 0;

    // bookkeeping
    int mismatches    = 0;
    int reports       = 0;
    int queued        = 0;
    int accepted      = 0;
    int samples_seen  = 0;
    int wrap_ticks    = 0;
    int muted_ticks   = 0;
    int glides        = 0;
    int scale_changes = 0;

    box_filtered_saw_oscillator uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_frequency     (i_frequency),
        .i_slide_samples (i_slide_samples),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_sample        (o_sample),
        .o_muted         (o_muted),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // saw averaged over the span swept by one tick, p = new phase, d = step
    function automatic logic signed [OUT_W-1:0] box_saw(input longint unsigned p,
                                                        input longint unsigned d);
        longint unsigned mag;
        longint unsigned rem;
        longint unsigned quo;
        longint          s;
        longint          val;
        bit              neg;
        if (p + d <= CYCLE) begin
            // span stays inside one cycle: mean of the ramp is its midpoint
            s   = 2 * p + d - CYCLE;
            neg = s < 0;
            mag = neg ? -s : s;
            mag = mag >> (PHASE_W - (OUT_W - 1));
        end else begin
            // span wraps: ((N - D)/N) * ((2N - 2P - D)/D), both as 32-bit fractions
            s   = 2 * CYCLE - 2 * p - d;
            neg = s < 0;
            rem = neg ? -s : s;
            quo = 0;
            for (int i = 0; i < FRACTION_W; i++) begin
                rem = rem << 1;
                quo = quo << 1;
                if (rem >= d) begin
                    rem = rem - d;
                    quo = quo | 64'd1;
                end
            end
            mag = ((CYCLE - d) * quo) >> (2 * FRACTION_W - (OUT_W - 1));
        end
        if (mag > OUT_HI + 1)
            mag = OUT_HI + 1;
        val = neg ? -longint'(mag) : longint'(mag);
        if (val > OUT_HI) val = OUT_HI;
        if (val < OUT_LO) val = OUT_LO;
        return val[OUT_W-1:0];
    endfunction

    // apply one accepted request to the predicted state, queue its sample if any
    task automatic advance_oscillator(input t_osc_req r);
        logic [71:0] prod;
        logic [71:0] target;
        longint      next_step;
        t_osc_sample res;
        case (r.action)
            bfso_pkg::ACT_SET_FREQ: begin
                prod   = r.frequency * inc_cfg;
                target = prod >> (64 - PHASE_W);
                if (target > STEP_MAX)
                    target = STEP_MAX;
                if (r.slide != 0) begin
                    // linear glide, per-tick step truncated toward zero
                    glide_inc  = (longint'(target) - longint'(osc_step)) / longint'(r.slide);
                    glide_left = r.slide;
                    glides++;
                end else begin
                    osc_step   = target[STEP_W-1:0];
                    glide_left = '0;
                end
            end
            bfso_pkg::ACT_RESET_PHASE: begin
                osc_phase = '0;
            end
            bfso_pkg::ACT_TICK: begin
                if (glide_left != 0) begin
                    next_step = longint'(osc_step) + glide_inc;
                    if (next_step < 0)
                        next_step = 0;
                    if (next_step > longint'(STEP_MAX))
                        next_step = STEP_MAX;
                    osc_step   = next_step[STEP_W-1:0];
                    glide_left = glide_left - 1'b1;
                end
                osc_phase = osc_phase + osc_step[PHASE_W-1:0];
                if (osc_step > CYCLE) begin
                    // more than a whole cycle per tick: silence
                    res.sample = '0;
                    res.muted  = 1'b1;
                    muted_ticks++;
                end else begin
                    if (64'(osc_phase) + 64'(osc_step) > CYCLE)
                        wrap_ticks++;
                    res.sample = box_saw(64'(osc_phase), 64'(osc_step));
                    res.muted  = 1'b0;
                end
                sample_q.push_back(res);
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // driver: one request per handshake, random gaps between requests
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_osc_req nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (send_gap != 0) begin
                i_in_valid <= 1'b0;
                send_gap   <= send_gap - 1;
            end else if (req_q.size() != 0) begin
                nxt = req_q.pop_front();
                i_in_valid      <= 1'b1;
                i_action        <= nxt.action;
                i_frequency     <= nxt.frequency;
                i_slide_samples <= nxt.slide;
                if (!calm && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 10);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure: random stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 15) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 9);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: check the sample leaving first, then predict the request entering
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_osc_sample want;
        t_osc_req    got_req;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                samples_seen++;
                if (sample_q.size() == 0) begin
                    mismatches++;
                    if (reports++ < MAX_REPORTS)
                        $display("%0t: unexpected sample %0d muted %0b, nothing pending",
                                 $time, o_sample, o_muted);
                end else begin
                    want = sample_q.pop_front();
                    if (o_sample !== want.sample || o_muted !== want.muted) begin
                        mismatches++;
                        if (reports++ < MAX_REPORTS)
                            $display("%0t: expected sample %0d muted %0b, got sample %0d muted %0b",
                                     $time, want.sample, want.muted, o_sample, o_muted);
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                got_req.action    = i_action;
                got_req.frequency = i_frequency;
                got_req.slide     = i_slide_samples;
                accepted++;
                advance_oscillator(got_req);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_request(input logic [ACT_W-1:0] act, input logic [FREQ_W-1:0] f,
                                 input logic [SLIDE_W-1:0] sl);
        t_osc_req r;
        r.action    = act;
        r.frequency = f;
        r.slide     = sl;
        req_q.push_back(r);
        queued++;
    endtask

    task automatic queue_tick();
        queue_request(bfso_pkg::ACT_TICK, FREQ_W'($urandom), SLIDE_W'($urandom));
    endtask

    // highest frequency whose step still stays within a whole phase period
    function automatic logic [FREQ_W-1:0] audible_ceiling();
        logic [64:0] lim;
        if (inc_cfg == '0)
            return '1;
        lim = (65'd1 << 64) / inc_cfg;
        return (lim > 65'hFF_FFFF) ? '1 : lim[FREQ_W-1:0];
    endfunction

    // frequencies weighted toward the useful range of the current scale
    function automatic logic [FREQ_W-1:0] pick_frequency();
        logic [FREQ_W-1:0] ceil_f;
        int                pick;
        ceil_f = audible_ceiling();
        pick   = $urandom_range(0, 9);
        if (pick < 5)
            return FREQ_W'($urandom_range(0, ceil_f));
        else if (pick < 7)
            return FREQ_W'($urandom_range(ceil_f / 2, ceil_f));    // near nyquist, wraps often
        else if (pick == 7)
            return FREQ_W'(ceil_f + $urandom_range(0, 6) - 3);
        else if (pick == 8)
            return FREQ_W'($urandom);
        else
            return $urandom_range(0, 1) ? '1 : '0;
    endfunction

    function automatic logic [SLIDE_W-1:0] pick_slide();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 10)
            return '0;
        else if (pick < 17)
            return SLIDE_W'($urandom_range(1, 16));
        else if (pick < 19)
            return SLIDE_W'($urandom_range(17, 2000));
        else
            return SLIDE_W'($urandom_range(1, (1 << SLIDE_W) - 1));
    endfunction

    // mostly set-frequency followed by a run of ticks, some lone requests as noise
    task automatic queue_random(input int count);
        int goal;
        int pick;
        goal = queued + count;
        while (queued < goal) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                case ($urandom_range(0, 2))
                    0: queue_tick();
                    1: queue_request(bfso_pkg::ACT_RESET_PHASE, FREQ_W'($urandom),
                                     SLIDE_W'($urandom));
                    default: queue_request(bfso_pkg::ACT_SET_FREQ, pick_frequency(),
                                           pick_slide());
                endcase
            end else begin
                queue_request(bfso_pkg::ACT_SET_FREQ, pick_frequency(), pick_slide());
                repeat ($urandom_range(3, 20)) begin
                    if ($urandom_range(0, 24) == 0)
                        queue_request(bfso_pkg::ACT_RESET_PHASE, FREQ_W'($urandom),
                                      SLIDE_W'($urandom));
                    queue_tick();
                end
            end
        end
    endtask

    // hold the sender until every request is in and every sample is back
    task automatic drain_all();
        while (req_q.size() != 0 || i_in_valid || sample_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // increment scale write, only ever issued with the block idle
    task automatic write_scale(input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        inc_cfg = value;
        scale_changes++;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset scale: zero step, plain tone, wrapping tone, mute, glides, phase reset
        queue_tick();                                                  // zero step from phase zero
        queue_request(bfso_pkg::ACT_SET_FREQ, 24'd7040, '0);           // 440 Hz jump
        repeat (3) queue_tick();
        queue_request(bfso_pkg::ACT_SET_FREQ, 24'd600000, '0);         // most of a cycle per tick
        repeat (4) queue_tick();
        queue_request(bfso_pkg::ACT_SET_FREQ, '1, '0);                 // far above one cycle
        queue_tick();
        queue_request(bfso_pkg::ACT_SET_FREQ, '0, 20'd4);              // glide down through the mute edge
        repeat (5) queue_tick();                                       // last one runs past the glide
        queue_request(bfso_pkg::ACT_RESET_PHASE, '1, '1);
        queue_tick();
        queue_request(bfso_pkg::ACT_SET_FREQ, '1, '1);                 // longest glide, tiny steps
        repeat (2) queue_tick();
        queue_request(bfso_pkg::ACT_SET_FREQ, 24'd7040, 20'd1);        // one-step glide
        queue_tick();
        queue_random(200);
        drain_all();

        // largest scale: almost everything mutes unless the frequency is tiny
        write_scale('1);
        queue_random(80);
        drain_all();

        // zero scale: every target step is zero
        write_scale('0);
        queue_random(40);
        drain_all();

        // scale where 131072 gives a step of exactly one cycle
        write_scale(48'h8000_0000_0000);
        queue_request(bfso_pkg::ACT_SET_FREQ, 24'd131072, '0);
        repeat (2) queue_tick();                                       // lands on the cycle edge
        queue_request(bfso_pkg::ACT_SET_FREQ, 24'd131071, '0);         // just under a cycle
        repeat (3) queue_tick();
        queue_request(bfso_pkg::ACT_SET_FREQ, 24'd131073, '0);         // just over: muted
        queue_tick();
        queue_request(bfso_pkg::ACT_RESET_PHASE, '0, '0);
        queue_request(bfso_pkg::ACT_SET_FREQ, 24'd131072, '0);
        queue_tick();
        queue_random(60);
        drain_all();

        write_scale(CFG_W'({$urandom, $urandom}));
        queue_random(100);
        drain_all();

        // back to the power-up scale, no idling on either side from here
        write_scale(bfso_pkg::CFG_RESET);
        calm = 1'b1;
        queue_random(120);
        drain_all();

        $display("covered %0d requests and %0d samples over %0d scale writes",
                 accepted, samples_seen, scale_changes);
        $display("%0d wrapped spans, %0d muted ticks, %0d glides started",
                 wrap_ticks, muted_ticks, glides);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("timeout with %0d samples still pending", sample_q.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/bfso_pkg.sv
hdl/bfso_div.sv
hdl/bfso_dp.sv
hdl/bfso_ctrl.sv
hdl/box_filtered_saw_oscillator.sv
tb/box_filtered_saw_oscillator_test.sv
